[rtl/sepbo_pkg.sv]
// ----------------------------------------------------------------------------
// sepbo_pkg: shared types and constants for the progress bar overlay
// Item structs, register indexes, sizing constants and the blend table.
// ----------------------------------------------------------------------------
package sepbo_pkg;

    // sizing
    localparam int MAX_DIM     = 4096;
    localparam int SIG_ENTRIES = 256;
    localparam int HALF        = SIG_ENTRIES / 2;
    localparam int QB          = $clog2(SIG_ENTRIES);     // blend table index bits
    localparam int EDGE_LOG2   = 4;                       // z carries 16 steps per unit
    localparam int Z_SHIFT     = QB - EDGE_LOG2;

    // register and field widths
    localparam int IMG_W   = 13;
    localparam int FRAME_W = 16;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 12;
    localparam int CH_W    = 8;

    localparam int DIM_W     = $clog2(MAX_DIM) + 1;       // clamped width, step
    localparam int MARK_W    = $clog2(MAX_DIM) + FRAME_W; // width*frame product
    localparam int DIV_STEPS = 4;                         // quotient bits per stage
    localparam int MDIV_ST   = (MARK_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int ZDIV_ST   = (QB + DIV_STEPS - 1) / DIV_STEPS;

    // blend factor, unsigned Q8
    localparam int F_W = 9;
    localparam logic [F_W-1:0] F_ONE  = F_W'(256);
    localparam logic [F_W-1:0] F_HALF = F_W'(128);

    // register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_index CFG_BAR_HEIGHT   = 3'd2;
    localparam t_cfg_index CFG_FRAME_COUNT  = 3'd3;
    localparam t_cfg_index CFG_COLOR_START  = 3'd4;
    localparam t_cfg_index CFG_COLOR_END    = 3'd5;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [CH_W-1:0]    in_red;
        logic [CH_W-1:0]    in_green;
        logic [CH_W-1:0]    in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } t_step_state;

    typedef logic [SIG_ENTRIES-1:0][F_W-1:0] t_blend_tab;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] EXP_CAP = 64'd1 << 45;

    // (a*b)>>30 split so the products stay inside 64 bits
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = b >> 15;
        lo = b & 64'h7FFF;
        return ((a * hi) >> 15) + ((a * lo) >> 30);
    endfunction

    // floor(num/den) for results below 2**F_W, by bitwise search
    function automatic logic [F_W-1:0] quot_small(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [F_W-1:0] f;
        logic [F_W-1:0] cand;
        f = '0;
        for (int b = F_W - 1; b >= 0; b--) begin
            cand = f | (F_W'(1) << b);
            if (64'(cand) * den <= num) begin
                f = cand;
            end
        end
        return f;
    endfunction

    // round(256*sigmoid(z/16)), exp kept in Q30 and grown by exp(1/16)
    function automatic t_blend_tab build_blend_tab();
        t_blend_tab  tab;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] den;
        tab  = '0;
        term = 64'd1 << 40;
        sum  = term;
        for (int k = 1; k <= 12; k++) begin
            term = term / 64'(16 * k);
            sum  = sum + term;
        end
        q = (sum + (64'd1 << 9)) >> 10;
        e = Q30_ONE;
        for (int k = 0; k <= HALF; k++) begin
            den = 64'd2 * (e + Q30_ONE);
            if (k < HALF) begin
                tab[HALF + k] = quot_small(64'd513 * e + Q30_ONE, den);
            end
            if (k >= 1) begin
                tab[HALF - k] = quot_small(64'd512 * Q30_ONE + e + Q30_ONE, den);
            end
            if (e < EXP_CAP) begin
                e = mul_q30(e, q);
            end
        end
        return tab;
    endfunction

    localparam t_blend_tab BLEND_TAB = build_blend_tab();

endpackage

[rtl/soft_edge_progress_bar_overlay_core.sv]
// ----------------------------------------------------------------------------
// soft_edge_progress_bar_overlay_core
// Pixel-stream overlay that paints a soft-edged progress bar on the bottom lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one pixel with
//   its position and frame number. Output channel (o_out_valid / i_out_stall /
//   o_out_item) returns the pixel, bar-blended or unchanged.
//   Config channel (i_cfg_valid / o_cfg_ready) writes one register per item;
//   it is always ready. Write only while no pixel is in flight.
//   Throughput: one pixel per cycle while o_in_stall is low. There are
//   16 register stages: input, multiply, the 7-stage mark divider (4 quotient
//   bits per stage), distance, magnitude, edge setup, the 2-stage edge
//   divider, blend factor and output. After reset and after every config
//   write, a sequential divider derives the edge step (width / frames);
//   o_in_stall is high meanwhile. Reset loads the default registers and
//   empties the pipeline. A stall on the output holds the result; bubbles
//   inside the pipeline still close up, so pixels keep being taken until
//   every stage is full.
// ----------------------------------------------------------------------------
module soft_edge_progress_bar_overlay_core
    import sepbo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_index       i_cfg_index,
    input  logic [COLOR_W-1:0] i_cfg_data
);

    localparam int S_IN    = 0;
    localparam int S_MUL   = 1;
    localparam int S_DIV0  = 2;
    localparam int S_DIFF  = S_DIV0 + MDIV_ST;
    localparam int S_ABS   = S_DIFF + 1;
    localparam int S_ZINIT = S_ABS + 1;
    localparam int S_ZDIV0 = S_ZINIT + 1;
    localparam int S_F     = S_ZDIV0 + ZDIV_ST;
    localparam int S_OUT   = S_F + 1;
    localparam int NSTG    = S_OUT + 1;
    localparam int CNT_W   = $clog2(DIM_W + 1);

    typedef struct packed {
        logic            bar;
        logic [PIX_W-1:0] px;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_carry;

    typedef struct packed {
        logic neg;
        logic eq;
        logic sat;
    } t_zflag;

    // ---------------- configuration ----------------
    logic [IMG_W-1:0]   r_image_width;
    logic [IMG_W-1:0]   r_image_height;
    logic [IMG_W-1:0]   r_bar_height;
    logic [FRAME_W-1:0] r_frame_count;
    logic [COLOR_W-1:0] r_color_start;
    logic [COLOR_W-1:0] r_color_end;
    logic               cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMG_W'(1920);
            r_image_height <= IMG_W'(1080);
            r_bar_height   <= IMG_W'(8);
            r_frame_count  <= FRAME_W'(30);
            r_color_start  <= COLOR_W'(24'hFF0000);
            r_color_end    <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMG_W-1:0];
                CFG_BAR_HEIGHT:   r_bar_height   <= i_cfg_data[IMG_W-1:0];
                CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[FRAME_W-1:0];
                CFG_COLOR_START:  r_color_start  <= i_cfg_data;
                CFG_COLOR_END:    r_color_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [FRAME_W-1:0] frames;

    assign w_eff  = (32'(r_image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_image_width);
    assign h_eff  = (32'(r_image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_image_height);
    assign frames = (r_frame_count == '0) ? FRAME_W'(1) : r_frame_count;

    // ---------------- step = w_eff / frames, sequential ----------------
    t_step_state      r_state;
    t_step_state      n_state;
    logic [DIM_W-1:0] r_sd_num;
    logic [FRAME_W-1:0] r_sd_rem;
    logic [CNT_W-1:0] r_sd_cnt;
    logic             step_busy;
    logic             sd_load;
    logic             sd_iter;
    logic [FRAME_W:0] sd_t;
    logic             step_zero;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cfg_wr) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = cfg_wr ? ST_LOAD : ST_DIV;
            end
            ST_DIV: begin
                if (cfg_wr) begin
                    n_state = ST_LOAD;
                end else if (r_sd_cnt == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        step_busy = 1'b1;
        sd_load   = 1'b0;
        sd_iter   = 1'b0;
        case (r_state)
            ST_IDLE: step_busy = 1'b0;
            ST_LOAD: sd_load   = 1'b1;
            ST_DIV:  sd_iter   = (r_sd_cnt != '0);
            default: step_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign sd_t = {r_sd_rem, r_sd_num[DIM_W-1]};

    always_ff @(posedge i_clk) begin
        if (sd_load) begin
            r_sd_num <= w_eff;
            r_sd_rem <= '0;
            r_sd_cnt <= CNT_W'(DIM_W);
        end else if (sd_iter) begin
            if (sd_t >= {1'b0, frames}) begin
                r_sd_rem <= FRAME_W'(sd_t - {1'b0, frames});
                r_sd_num <= {r_sd_num[DIM_W-2:0], 1'b1};
            end else begin
                r_sd_rem <= sd_t[FRAME_W-1:0];
                r_sd_num <= {r_sd_num[DIM_W-2:0], 1'b0};
            end
            r_sd_cnt <= r_sd_cnt - CNT_W'(1);
        end
    end

    assign step_zero = (r_sd_num == '0);

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] rdy;
    logic            in_take;

    always_comb begin
        rdy[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_in_stall  = step_busy || !rdy[S_IN];
    assign in_take     = i_in_valid && !step_busy;
    assign o_out_valid = r_v[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? in_take : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // pass-through data and bar flag travel with every stage
    t_carry in_carry;
    t_carry r_carry [NSTG];

    always_comb begin
        in_carry.bar   = (32'(i_in_item.pixel_x) < 32'(w_eff))
                      && (32'(i_in_item.pixel_y) < 32'(h_eff))
                      && (32'(i_in_item.pixel_y) + 32'(r_bar_height) >= 32'(h_eff));
        in_carry.px    = i_in_item.pixel_x;
        in_carry.red   = i_in_item.in_red;
        in_carry.green = i_in_item.in_green;
        in_carry.blue  = i_in_item.in_blue;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_carry[k] <= (k == 0) ? in_carry : r_carry[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ---------------- mark = w_eff * frame / frames ----------------
    logic [FRAME_W-1:0] r_fi;
    logic [MARK_W-1:0]  r_prod;
    logic [MARK_W-1:0]  r_md_num [MDIV_ST];
    logic [FRAME_W-1:0] r_md_rem [MDIV_ST];
    logic [MARK_W-1:0]  n_md_num [MDIV_ST];
    logic [FRAME_W-1:0] n_md_rem [MDIV_ST];

    always_ff @(posedge i_clk) begin
        if (rdy[S_IN])  r_fi   <= i_in_item.frame_index;
        if (rdy[S_MUL]) r_prod <= MARK_W'(w_eff) * MARK_W'(r_fi);
    end

    // restoring division, DIV_STEPS quotient bits per stage
    always_comb begin
        logic [MARK_W-1:0]  num;
        logic [FRAME_W-1:0] rem;
        logic [FRAME_W:0]   t;
        logic               qb;
        for (int j = 0; j < MDIV_ST; j++) begin
            num = (j == 0) ? r_prod : r_md_num[(j == 0) ? 0 : j - 1];
            rem = (j == 0) ? '0 : r_md_rem[(j == 0) ? 0 : j - 1];
            for (int i = 0; i < DIV_STEPS; i++) begin
                if (j * DIV_STEPS + i < MARK_W) begin
                    t  = {rem, num[MARK_W-1]};
                    qb = (t >= {1'b0, frames});
                    rem = qb ? FRAME_W'(t - {1'b0, frames}) : t[FRAME_W-1:0];
                    num = {num[MARK_W-2:0], qb};
                end
            end
            n_md_num[j] = num;
            n_md_rem[j] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MDIV_ST; j++) begin
            if (rdy[S_DIV0 + j]) begin
                r_md_num[j] <= n_md_num[j];
                r_md_rem[j] <= n_md_rem[j];
            end
        end
    end

    // ---------------- distance to the mark ----------------
    logic signed [MARK_W:0] r_diff;
    logic [MARK_W-1:0]      r_adist;
    logic                   r_abs_neg;
    logic                   r_abs_eq;
    logic signed [MARK_W:0] diff_mag;

    assign diff_mag = r_diff[MARK_W] ? -r_diff : r_diff;

    always_ff @(posedge i_clk) begin
        if (rdy[S_DIFF]) begin
            r_diff <= $signed({1'b0, MARK_W'(r_carry[S_DIFF-1].px)})
                    - $signed({1'b0, r_md_num[MDIV_ST-1]});
        end
        if (rdy[S_ABS]) begin
            r_adist   <= diff_mag[MARK_W-1:0];
            r_abs_neg <= r_diff[MARK_W];
            r_abs_eq  <= (r_diff == '0);
        end
    end

    // ---------------- z = |d|*16 / step, saturated ----------------
    t_zflag              r_zi;
    logic [DIM_W-1:0]    r_zi_rem;
    logic [QB-1:0]       r_zi_low;
    logic [MARK_W+EDGE_LOG2-1:0] scaled;
    t_zflag              r_zd_flag [ZDIV_ST];
    logic [QB-1:0]       r_zd_num  [ZDIV_ST];
    logic [DIM_W-1:0]    r_zd_rem  [ZDIV_ST];
    logic [QB-1:0]       n_zd_num  [ZDIV_ST];
    logic [DIM_W-1:0]    n_zd_rem  [ZDIV_ST];

    assign scaled = {r_adist, {EDGE_LOG2{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (rdy[S_ZINIT]) begin
            r_zi.neg <= r_abs_neg;
            r_zi.eq  <= r_abs_eq;
            // quotient reaches 2**QB or more
            r_zi.sat <= (MARK_W+1)'(r_adist) >= ((MARK_W+1)'(r_sd_num) << Z_SHIFT);
            r_zi_rem <= DIM_W'(r_adist >> Z_SHIFT);
            r_zi_low <= scaled[QB-1:0];
        end
    end

    always_comb begin
        logic [QB-1:0]    num;
        logic [DIM_W-1:0] rem;
        logic [DIM_W:0]   t;
        logic             qb;
        for (int j = 0; j < ZDIV_ST; j++) begin
            num = (j == 0) ? r_zi_low : r_zd_num[(j == 0) ? 0 : j - 1];
            rem = (j == 0) ? r_zi_rem : r_zd_rem[(j == 0) ? 0 : j - 1];
            for (int i = 0; i < DIV_STEPS; i++) begin
                if (j * DIV_STEPS + i < QB) begin
                    t  = {rem, num[QB-1]};
                    qb = (t >= {1'b0, r_sd_num});
                    rem = qb ? DIM_W'(t - {1'b0, r_sd_num}) : t[DIM_W-1:0];
                    num = {num[QB-2:0], qb};
                end
            end
            n_zd_num[j] = num;
            n_zd_rem[j] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ZDIV_ST; j++) begin
            if (rdy[S_ZDIV0 + j]) begin
                r_zd_num[j]  <= n_zd_num[j];
                r_zd_rem[j]  <= n_zd_rem[j];
                r_zd_flag[j] <= (j == 0) ? r_zi : r_zd_flag[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---------------- blend factor ----------------
    logic [F_W-1:0] r_f;
    logic [F_W-1:0] n_f;

    always_comb begin
        logic [QB-1:0] q;
        logic [QB:0]   qc;
        logic [QB:0]   idx;
        t_zflag        fl;
        q  = r_zd_num[ZDIV_ST-1];
        fl = r_zd_flag[ZDIV_ST-1];
        if (!fl.neg) begin
            qc  = (fl.sat || (QB+1)'(q) >= (QB+1)'(HALF - 1)) ? (QB+1)'(HALF - 1)
                                                              : (QB+1)'(q);
            idx = (QB+1)'(HALF) + qc;
        end else begin
            qc  = (fl.sat || (QB+1)'(q) >= (QB+1)'(HALF)) ? (QB+1)'(HALF) : (QB+1)'(q);
            idx = (QB+1)'(HALF) - qc;
        end
        if (step_zero) begin
            n_f = fl.neg ? '0 : (fl.eq ? F_HALF : F_ONE);
        end else begin
            n_f = BLEND_TAB[idx[QB-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_F]) r_f <= n_f;
    end

    // ---------------- color blend ----------------
    // (c0*(256-f) + c1*f) >> 8 == c0 + floor((c1-c0)*f / 256)
    function automatic logic [CH_W-1:0] blend_chan(input logic [CH_W-1:0] c0,
                                                   input logic [CH_W-1:0] c1,
                                                   input logic [F_W-1:0]  f);
        logic signed [CH_W:0] dc;
        logic signed [18:0]   pm;
        logic [18:0]          sum;
        dc  = $signed({1'b0, c1}) - $signed({1'b0, c0});
        pm  = 19'(dc) * 19'($signed({1'b0, f}));
        sum = {11'b0, c0} + 19'(pm >>> 8);
        return sum[CH_W-1:0];
    endfunction

    t_out_item r_out;
    t_out_item n_out;
    t_carry    cf;

    always_comb begin
        cf = r_carry[S_OUT-1];
        if (cf.bar) begin
            n_out.out_red   = blend_chan(r_color_start[23:16], r_color_end[23:16], r_f);
            n_out.out_green = blend_chan(r_color_start[15:8],  r_color_end[15:8],  r_f);
            n_out.out_blue  = blend_chan(r_color_start[7:0],   r_color_end[7:0],   r_f);
        end else begin
            n_out.out_red   = cf.red;
            n_out.out_green = cf.green;
            n_out.out_blue  = cf.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_OUT]) r_out <= n_out;
    end

    assign o_out_item = r_out;

`ifndef ASSERT_OFF
    // a config write holds off pixels while the step is recomputed
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> o_in_stall)
        else $error("pixel accepted right after a config write");

    // the step unit ends with floor(w_eff / frames)
    a_step_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(step_busy) |->
            (32'(r_sd_num) * 32'(frames) <= 32'(w_eff))
            && ((32'(r_sd_num) + 32'd1) * 32'(frames) > 32'(w_eff)))
        else $error("step divider result wrong");

    a_mark_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_DIV0 + MDIV_ST - 1] |-> (r_md_rem[MDIV_ST-1] < frames))
        else $error("mark divider remainder out of range");

    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_F] |-> (r_f <= F_ONE))
        else $error("blend factor above one");
`endif

endmodule

[tb/soft_edge_progress_bar_overlay_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soft_edge_progress_bar_overlay_core_tb
// Drives pixels through the overlay core under random input gaps and output
// stalls, and checks every returned pixel against a typed value or a model
// of the bar blend. A directed script comes first, then random register
// settings, each followed by pixels mostly on bar rows, half near the mark.
// ----------------------------------------------------------------------------
module soft_edge_progress_bar_overlay_core_tb;
    import sepbo_pkg::*;

    // indexes past the register list; writes there must be ignored
    localparam t_cfg_index CFG_SPARE_LO = 3'd6;
    localparam t_cfg_index CFG_SPARE_HI = 3'd7;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] GROW_CAP = 64'd1 << 45;

    typedef struct {
        bit           is_cfg;
        t_cfg_index   idx;
        logic [23:0]  data;
        t_in_item     pix;
        bit           typed;
        t_out_item    want;
    } t_script_row;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_index       cfg_index = CFG_IMAGE_WIDTH;
    logic [COLOR_W-1:0] cfg_data = '0;

    logic [F_W-1:0]   edge_lut [SIG_ENTRIES];
    logic [12:0]      cfg_width;
    logic [12:0]      cfg_height;
    logic [12:0]      cfg_bar;
    logic [15:0]      cfg_frames;
    logic [23:0]      cfg_c0;
    logic [23:0]      cfg_c1;

    t_out_item        pending_px [$];
    t_script_row      script [$];
    int               err_cnt = 0;
    bit               rush = 1'b0;

    soft_edge_progress_bar_overlay_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // model of the blend
    // ------------------------------------------------------------------
    function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
        return ((a * (b >> 15)) >> 15) + ((a * (b & 64'h7FFF)) >> 30);
    endfunction

    // logistic table, exp(z/16) grown in Q30 by a series value of exp(1/16)
    function automatic void fill_edge_lut();
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] grow;
        logic [63:0] ex;
        logic [63:0] den;
        logic [63:0] up;
        logic [63:0] dn;
        term = 64'd1 << 40;
        acc  = term;
        for (int k = 1; k <= 12; k++) begin
            term = term / (64'd16 * k);
            acc  = acc + term;
        end
        grow = (acc + (64'd1 << 9)) >> 10;
        ex   = ONE_Q30;
        for (int k = 0; k <= HALF; k++) begin
            den = 64'd2 * (ex + ONE_Q30);
            up  = (64'd513 * ex + ONE_Q30) / den;
            dn  = (64'd512 * ONE_Q30 + ex + ONE_Q30) / den;
            if (k < HALF) begin
                edge_lut[HALF + k] = up[F_W-1:0];
            end
            if (k >= 1) begin
                edge_lut[HALF - k] = dn[F_W-1:0];
            end
            if (ex < GROW_CAP) begin
                ex = fix_mul(ex, grow);
            end
        end
    endfunction

    function automatic t_out_item overlay_pixel(t_in_item p);
        longint    w;
        longint    h;
        longint    frames;
        longint    mark;
        longint    stride;
        longint    z;
        int        f;
        int        c0;
        int        c1;
        logic [23:0] mix;
        w      = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
        h      = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        frames = (cfg_frames == 0) ? 1 : cfg_frames;
        if (p.pixel_x >= w || p.pixel_y >= h || longint'(p.pixel_y) + cfg_bar < h) begin
            return {p.in_red, p.in_green, p.in_blue};
        end
        mark   = w * longint'(p.frame_index) / frames;
        stride = w / frames;
        if (stride == 0) begin
            if (p.pixel_x > mark) f = 256;
            else if (p.pixel_x == mark) f = 128;
            else f = 0;
        end else begin
            // signed division truncates toward zero
            z = (longint'(p.pixel_x) - mark) * 16 / stride;
            if (z < -HALF) z = -HALF;
            if (z > HALF - 1) z = HALF - 1;
            f = edge_lut[z + HALF];
        end
        for (int ch = 0; ch < 3; ch++) begin
            c0 = (cfg_c0 >> (16 - 8 * ch)) & 8'hFF;
            c1 = (cfg_c1 >> (16 - 8 * ch)) & 8'hFF;
            mix[16 - 8 * ch +: 8] = 8'((c0 * (256 - f) + c1 * f) >> 8);
        end
        return t_out_item'(mix);
    endfunction

    function automatic void load_reg(t_cfg_index idx, logic [23:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = data[12:0];
            CFG_IMAGE_HEIGHT: cfg_height = data[12:0];
            CFG_BAR_HEIGHT:   cfg_bar    = data[12:0];
            CFG_FRAME_COUNT:  cfg_frames = data[15:0];
            CFG_COLOR_START:  cfg_c0     = data;
            CFG_COLOR_END:    cfg_c1     = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_wait();
        return rush ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [23:0] data);
        t_script_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        script.push_back(r);
    endfunction

    function automatic void add_pix(logic [15:0] fi, logic [11:0] x, logic [11:0] y,
                                    logic [23:0] rgb, bit typed, logic [23:0] want);
        t_script_row r;
        r = '{default: '0};
        r.pix   = {fi, x, y, rgb};
        r.typed = typed;
        r.want  = t_out_item'(want);
        script.push_back(r);
    endfunction

    // mostly bar rows, half of them near the mark; a quarter pure noise
    function automatic t_in_item random_pixel();
        t_in_item p;
        int w;
        int h;
        int fr;
        int lo_y;
        int mark;
        int span;
        int x;
        p  = t_in_item'({$urandom, $urandom});
        w  = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
        h  = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        fr = (cfg_frames == 0) ? 1 : cfg_frames;
        if (w == 0 || h == 0 || $urandom_range(0, 3) == 0) begin
            return p;
        end
        lo_y = h - int'(cfg_bar);
        if (lo_y > h - 2) lo_y = h - 2;
        if (lo_y < 0) lo_y = 0;
        p.pixel_y = 12'($urandom_range(lo_y, h - 1));
        if ($urandom_range(0, 4) != 0) begin
            p.frame_index = 16'($urandom_range(0, fr - 1));
        end
        mark = w * int'(p.frame_index) / fr;
        if ($urandom_range(0, 1) == 0) begin
            span = 9 * (w / fr) + 2;
            x = mark + int'($urandom_range(0, 2 * span)) - span;
        end else begin
            x = int'($urandom_range(0, w - 1));
        end
        if (x > w - 1) x = w - 1;
        if (x < 0) x = 0;
        p.pixel_x = 12'(x);
        return p;
    endfunction

    task automatic send_pixel(t_in_item p, bit typed, t_out_item want);
        int gap;
        gap = draw_wait();
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_px.push_back(typed ? want : overlay_pixel(p));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
    endtask

    // leaves the write valid high so writes can run back to back
    task automatic write_reg(t_cfg_index idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        load_reg(idx, data);
    endtask

    function automatic logic [23:0] pick_dim(int sel);
        case (sel)
            0: return 24'($urandom_range(1, MAX_DIM));
            1: return 24'd1;
            2: return 24'(MAX_DIM);
            3: return 24'($urandom);
            default: return 24'($urandom_range(16, 300));
        endcase
    endfunction

    task automatic program_phase(int ph);
        logic [23:0] fr;
        logic [23:0] bar;
        case ((ph * 3) % 5)
            0: fr = 24'($urandom_range(1, 48));
            1: fr = 24'd0;
            2: fr = 24'd65535;
            3: fr = 24'($urandom_range(1, 65535));
            default: fr = 24'd1;
        endcase
        case (ph % 4)
            0: bar = 24'($urandom_range(1, 24));
            1: bar = 24'd0;
            2: bar = 24'(MAX_DIM);
            default: bar = 24'($urandom);
        endcase
        drain_pipe();
        write_reg(CFG_IMAGE_WIDTH, pick_dim(ph % 5));
        write_reg(CFG_IMAGE_HEIGHT, pick_dim((ph + 2) % 5));
        write_reg(CFG_BAR_HEIGHT, bar);
        write_reg(CFG_FRAME_COUNT, fr);
        write_reg(CFG_COLOR_START, (ph == 1) ? 24'h000000 :
                                   (ph == 2) ? 24'hFFFFFF : 24'($urandom));
        write_reg(CFG_COLOR_END, (ph == 1) ? 24'hFFFFFF :
                                 (ph == 2) ? 24'h000000 : 24'($urandom));
        if (ph % 2 == 1) begin
            write_reg((ph % 4 == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    initial begin
        int hold;
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rst_n && out_valid && !out_stall)) @(posedge clk);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %02h got %02h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_px.size() == 0) begin
                $error("pixel %06h returned with nothing outstanding", out_item);
                err_cnt++;
            end else begin
                want = pending_px.pop_front();
                check_field("out_red", want.out_red, out_item.out_red);
                check_field("out_green", want.out_green, out_item.out_green);
                check_field("out_blue", want.out_blue, out_item.out_blue);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        fill_edge_lut();
        cfg_width  = 13'd1920;
        cfg_height = 13'd1080;
        cfg_bar    = 13'd8;
        cfg_frames = 16'd30;
        cfg_c0     = 24'hFF0000;
        cfg_c1     = 24'h000000;

        // defaults: 1920x1080, 8 bar lines, 30 frames, red to black
        add_pix(16'd0, 12'd0, 12'd0, 24'h000000, 1, 24'h000000);
        add_pix(16'hFFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 1, 24'hFFFFFF);
        add_pix(16'd0, 12'd0, 12'd1079, 24'h123456, 1, 24'h7F0000);
        add_pix(16'd0, 12'd1919, 12'd1072, 24'h123456, 1, 24'h000000);
        add_pix(16'd29, 12'd0, 12'd1079, 24'h654321, 1, 24'hFF0000);
        // mark far past the right edge
        add_pix(16'hFFFF, 12'd1919, 12'd1075, 24'h0F0F0F, 1, 24'hFF0000);
        add_pix(16'd5, 12'd100, 12'd1071, 24'hA55AC3, 1, 24'hA55AC3);
        add_pix(16'd5, 12'd1920, 12'd1079, 24'h5AA53C, 1, 24'h5AA53C);
        add_pix(16'd15, 12'd960, 12'd1079, 24'h000000, 1, 24'h7F0000);
        add_pix(16'd15, 12'd961, 12'd1079, 24'h000000, 0, 24'h0);
        add_pix(16'd15, 12'd950, 12'd1076, 24'h000000, 0, 24'h0);
        add_pix(16'd15, 12'd990, 12'd1073, 24'h000000, 0, 24'h0);
        add_cfg(CFG_COLOR_START, 24'h123456);
        add_cfg(CFG_COLOR_END, 24'hFEDCBA);
        add_pix(16'd10, 12'd630, 12'd1075, 24'h000000, 0, 24'h0);
        // zero frame count acts as one
        add_cfg(CFG_FRAME_COUNT, 24'd0);
        add_pix(16'd0, 12'd1919, 12'd1079, 24'h000000, 0, 24'h0);
        add_pix(16'd1, 12'd1919, 12'd1079, 24'h000000, 0, 24'h0);
        // zero step: hard edge at the mark (mark 29 for frame 1000)
        add_cfg(CFG_FRAME_COUNT, 24'd65535);
        add_pix(16'd1000, 12'd29, 12'd1079, 24'h000000, 1, 24'h888888);
        add_pix(16'd1000, 12'd30, 12'd1079, 24'h000000, 1, 24'hFEDCBA);
        add_pix(16'd1000, 12'd28, 12'd1079, 24'h000000, 1, 24'h123456);
        add_pix(16'hFFFF, 12'd1919, 12'd1079, 24'h000000, 1, 24'h123456);
        // oversized dimensions clamp; bar taller than the frame covers it
        add_cfg(CFG_IMAGE_WIDTH, 24'hFFFFFF);
        add_cfg(CFG_IMAGE_HEIGHT, 24'hFFFFFF);
        add_cfg(CFG_BAR_HEIGHT, 24'hFFFFFF);
        add_pix(16'd0, 12'd4095, 12'd0, 24'h000000, 1, 24'hFEDCBA);
        add_pix(16'd0, 12'd0, 12'd4095, 24'h000000, 1, 24'h888888);
        add_cfg(CFG_SPARE_LO, 24'hFFFFFF);
        add_cfg(CFG_SPARE_HI, 24'hFFFFFF);
        add_pix(16'd0, 12'd0, 12'd2000, 24'h000000, 0, 24'h0);
        add_cfg(CFG_BAR_HEIGHT, 24'd0);
        add_pix(16'd0, 12'd0, 12'd4095, 24'hC3C3C3, 1, 24'hC3C3C3);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain_pipe();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_pixel(script[i].pix, script[i].typed, script[i].want);
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            program_phase(ph);
            for (int n = 0; n < 90; n++) begin
                if (n % 30 == 0) rush = ($urandom_range(0, 3) == 0);
                send_pixel(random_pixel(), 0, '0);
            end
        end

        rush = 1'b0;
        drain_pipe();
        repeat (24) @(posedge clk);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/sepbo_pkg.sv
rtl/soft_edge_progress_bar_overlay_core.sv
tb/soft_edge_progress_bar_overlay_core_tb.sv
